@@ hdl/modexp_pkg.sv @@
package modexp_pkg;

    // Word width of modulus, exponent, base and result
    localparam int WORD_WIDTH = 32;
    // Counter width for one pass over the bits of a word
    localparam int BIT_CNT_W  = $clog2(WORD_WIDTH);
    // Sum width inside the modular multiply step: 2*acc + a < 3*m
    localparam int SUM_W      = WORD_WIDTH + 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MUL,
        ST_SQR
    } modexp_state_t;

    // Request to the shared modular multiplier
    typedef struct packed {
        logic                  go;
        logic [WORD_WIDTH-1:0] mcand;
        logic [WORD_WIDTH-1:0] mplier;
    } modexp_mm_req_t;

    // Response from the shared modular multiplier
    typedef struct packed {
        logic                  done;
        logic [WORD_WIDTH-1:0] product;
    } modexp_mm_rsp_t;

endpackage

@@ hdl/modular_exponentiation.sv @@
// Channel        Ports                                 Handshake
// -------------  ------------------------------------  ---------------------------------
// config write   cfg_we, cfg_index, cfg_data           taken on any edge with cfg_we high
// base in        start, busy, base_value               taken when start && !busy
// result out     done, power_result                    valid for the one cycle done is high
//
// The result of a zero exponent or a zero modulus needs no multiplier; otherwise the
// base is reduced, then each exponent bit takes a square, after a multiply when the
// bit is set, all on the single bit-serial modular multiplier.
// Reset (rst_n low, asynchronous) leaves modulus = 1, exponent = 0 and the block idle.
// The result strobe cannot be stalled; done is high for exactly one cycle.
module modular_exponentiation (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [modexp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [modexp_pkg::WORD_WIDTH-1:0]       cfg_data,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [modexp_pkg::WORD_WIDTH-1:0]       base_value,
    output logic                                    done,
    output logic [modexp_pkg::WORD_WIDTH-1:0]       power_result
);
    import modexp_pkg::*;

    // Configuration registers
    logic [WORD_WIDTH-1:0] modulus_reg;
    logic [WORD_WIDTH-1:0] exponent_reg;

    // Sequencer state
    modexp_state_t         state_reg, state_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [WORD_WIDTH-1:0] exp_reg, exp_next;     // exponent, shifted right per bit
    logic [WORD_WIDTH-1:0] base_reg, base_next;   // running square of the base
    logic [WORD_WIDTH-1:0] acc_reg, acc_next;     // running product
    logic                  done_reg, done_next;
    logic [WORD_WIDTH-1:0] result_reg, result_next;

    modexp_mm_req_t mm_req;
    modexp_mm_rsp_t mm_rsp;

    logic last_bit;

    // Write configuration; an index beyond the list is dropped by the case default
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= WORD_WIDTH'(1);
            exponent_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODULUS:  modulus_reg  <= cfg_data;
                CFG_EXPONENT: exponent_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Shared modular multiplier: base reduction, multiply and square all go here
    modexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    assign last_bit = (bit_cnt_reg == BIT_CNT_W'(WORD_WIDTH - 1));

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        exp_next     = exp_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        mm_req.go     = 1'b0;
        mm_req.mcand  = WORD_WIDTH'(1);
        mm_req.mplier = base_value;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (exponent_reg == '0)
                    begin
                        // Zero exponent: answer 1 with no reduction
                        result_next = WORD_WIDTH'(1);
                        done_next   = 1'b1;
                    end
                    else if (modulus_reg == '0)
                    begin
                        result_next = '0;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        // Reduce the base: (1 * base) mod modulus
                        mm_req.go     = 1'b1;
                        mm_req.mcand  = WORD_WIDTH'(1);
                        mm_req.mplier = base_value;
                        exp_next      = exponent_reg;
                        bit_cnt_next  = '0;
                        state_next    = ST_REDUCE;
                    end
                end
            end

            ST_REDUCE:
            begin
                if (mm_rsp.done)
                begin
                    base_next  = mm_rsp.product;
                    acc_next   = (modulus_reg == WORD_WIDTH'(1)) ? '0 : WORD_WIDTH'(1);
                    state_next = ST_STEP;
                end
            end

            ST_STEP:
            begin
                // Multiply into the product when the exponent bit is set, else square
                mm_req.go = 1'b1;
                if (exp_reg[0])
                begin
                    mm_req.mcand  = acc_reg;
                    mm_req.mplier = base_reg;
                    state_next    = ST_MUL;
                end
                else
                begin
                    mm_req.mcand  = base_reg;
                    mm_req.mplier = base_reg;
                    state_next    = ST_SQR;
                end
            end

            ST_MUL:
            begin
                if (mm_rsp.done)
                begin
                    acc_next      = mm_rsp.product;
                    mm_req.go     = 1'b1;
                    mm_req.mcand  = base_reg;
                    mm_req.mplier = base_reg;
                    state_next    = ST_SQR;
                end
            end

            ST_SQR:
            begin
                if (mm_rsp.done)
                begin
                    base_next    = mm_rsp.product;
                    exp_next     = {1'b0, exp_reg[WORD_WIDTH-1:1]};
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    if (last_bit)
                    begin
                        result_next = acc_reg;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_STEP;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            done_reg    <= done_next;
        end
    end

    // Datapath registers hold their value; no reset needed
    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign power_result = result_reg;

endmodule

@@ hdl/modexp_mulmod.sv @@
module modexp_mulmod (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [modexp_pkg::WORD_WIDTH-1:0]   modulus,
    input  modexp_pkg::modexp_mm_req_t          req,
    output modexp_pkg::modexp_mm_rsp_t          rsp
);
    import modexp_pkg::*;

    // MSB-first interleaved multiply: acc = (2*acc + bit*mcand) mod modulus,
    // one multiplier bit per cycle. With mcand = 1 this reduces mplier mod modulus.
    logic                  active_reg, active_next;
    logic                  done_reg,   done_next;
    logic [BIT_CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [WORD_WIDTH-1:0] acc_reg,    acc_next;
    logic [WORD_WIDTH-1:0] mcand_reg,  mcand_next;
    logic [WORD_WIDTH-1:0] mplier_reg, mplier_next;

    logic [SUM_W-1:0] sum;
    logic [SUM_W:0]   diff1;
    logic [SUM_W:0]   diff2;
    logic [SUM_W-1:0] reduced;

    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0}
            + (mplier_reg[WORD_WIDTH-1] ? {2'b00, mcand_reg} : {SUM_W{1'b0}});
        diff1 = {1'b0, sum} - {3'b000, modulus};
        diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
        if (!diff2[SUM_W])
            reduced = diff2[SUM_W-1:0];
        else if (!diff1[SUM_W])
            reduced = diff1[SUM_W-1:0];
        else
            reduced = sum;
    end

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (req.go)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = req.mcand;
            mplier_next = req.mplier;
        end
        else if (active_reg)
        begin
            acc_next    = reduced[WORD_WIDTH-1:0];
            mplier_next = {mplier_reg[WORD_WIDTH-2:0], 1'b0};
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == BIT_CNT_W'(WORD_WIDTH - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

@@ hdl/modexp_checker.sv @@
module modexp_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    import modexp_pkg::*;

    // A result never shows while a transaction is still running
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // An accepted transaction either starts work or finishes at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction dropped");

    // Leaving busy always delivers the result
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    // Busy only rises after an accepted start
    a_rise_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

@@ bench/modular_exponentiation_test.sv @@
module modular_exponentiation_test;

    import modexp_pkg::*;

    // Random bases after the directed table
    localparam int RANDOM_BASES  = 250;
    // Quiet cycles after the last result; a bit more than the slowest transaction
    localparam int SETTLE_CYCLES = 2200;
    // Worst case per transaction is the slowest busy stretch plus the longest random gap;
    // over ~300 transactions the limit allows several times that total
    localparam int CYCLE_LIMIT   = 6_000_000;

    // One row of the directed table. When write_keys is set, program the modulus
    // and exponent of the row first. When known is set, the power column holds
    // the answer; otherwise it comes from the predictor.
    typedef struct packed {
        logic                  write_keys;
        logic [WORD_WIDTH-1:0] modulus;
        logic [WORD_WIDTH-1:0] exponent;
        logic [WORD_WIDTH-1:0] base;
        logic                  known;
        logic [WORD_WIDTH-1:0] power;
    } vector_t;

    // One accepted base and the power it must produce
    typedef struct packed {
        logic [WORD_WIDTH-1:0] base;
        logic [WORD_WIDTH-1:0] modulus;
        logic [WORD_WIDTH-1:0] exponent;
        logic [WORD_WIDTH-1:0] power;
    } power_txn_t;

    localparam int DIRECTED_COUNT = 22;
    localparam vector_t DIRECTED [0:DIRECTED_COUNT-1] = '{
        // reset keys: exponent zero gives one for any base
        '{1'b0, 32'd1,        32'd0,        32'h00000000, 1'b1, 32'd1},
        '{1'b0, 32'd1,        32'd0,        32'hFFFFFFFF, 1'b1, 32'd1},
        // modulus one with a nonzero exponent gives zero
        '{1'b1, 32'd1,        32'd5,        32'd7,        1'b1, 32'd0},
        // exponent zero wins over modulus one
        '{1'b1, 32'd1,        32'd0,        32'd7,        1'b1, 32'd1},
        // modulus zero: zero with a nonzero exponent, one with exponent zero
        '{1'b1, 32'd0,        32'd3,        32'd9,        1'b1, 32'd0},
        '{1'b1, 32'd0,        32'd0,        32'd9,        1'b1, 32'd1},
        // largest modulus, exponent one: plain reduction of the base
        '{1'b1, 32'hFFFFFFFF, 32'd1,        32'hFFFFFFFF, 1'b1, 32'd0},
        '{1'b0, 32'hFFFFFFFF, 32'd1,        32'hFFFFFFFE, 1'b1, 32'hFFFFFFFE},
        '{1'b0, 32'hFFFFFFFF, 32'd1,        32'h12345678, 1'b0, 32'd0},
        // largest exponent: zero, one and minus one stay put (odd exponent)
        '{1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'd0},
        '{1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000001, 1'b1, 32'd1},
        '{1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE, 1'b1, 32'hFFFFFFFE},
        '{1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hDEADBEEF, 1'b0, 32'd0},
        // minus one squared is one
        '{1'b1, 32'hFFFFFFFF, 32'd2,        32'hFFFFFFFE, 1'b1, 32'd1},
        // small RSA key pair: encrypt, then decrypt back
        '{1'b1, 32'd3233,     32'd17,       32'd65,       1'b0, 32'd0},
        '{1'b1, 32'd3233,     32'd2753,     32'd2790,     1'b0, 32'd0},
        // prime modulus with exponent p-1, base both below and above the modulus
        '{1'b1, 32'hFFFFFFFB, 32'hFFFFFFFA, 32'd123456789, 1'b0, 32'd0},
        '{1'b0, 32'hFFFFFFFB, 32'hFFFFFFFA, 32'hFFFFFFFF, 1'b0, 32'd0},
        // single top bit in both keys
        '{1'b1, 32'h80000000, 32'h80000000, 32'd3,        1'b0, 32'd0},
        // modulus two: parity of the base
        '{1'b1, 32'd2,        32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd1},
        '{1'b0, 32'd2,        32'hFFFFFFFF, 32'hFFFFFFFE, 1'b1, 32'd0},
        // alternating bit patterns
        '{1'b1, 32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAA, 1'b0, 32'd0}
    };

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MODULUS;
    logic [WORD_WIDTH-1:0] cfg_data = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [WORD_WIDTH-1:0] base_value = '0;
    logic                  done;
    logic [WORD_WIDTH-1:0] power_result;

    // Shadow copy of the key registers, as the block holds them
    logic [WORD_WIDTH-1:0] key_modulus = 32'd1;
    logic [WORD_WIDTH-1:0] key_exponent = '0;

    power_txn_t pending_powers[$];
    power_txn_t oldest_power;
    bit         steady = 1'b0;
    int         fail_count = 0;
    int         bases_sent = 0;
    int         powers_checked = 0;
    int         key_settings = 0;
    int         cycle_count = 0;

    modular_exponentiation dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .base_value   (base_value),
        .done         (done),
        .power_result (power_result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // base^exponent mod modulus by right-to-left square-and-multiply. Operands
    // stay below the modulus, so every 32x32 product fits in 64 bits.
    function automatic logic [WORD_WIDTH-1:0] predict_power(
        input logic [WORD_WIDTH-1:0] m,
        input logic [WORD_WIDTH-1:0] e,
        input logic [WORD_WIDTH-1:0] b
    );
        longint unsigned md;
        longint unsigned square;
        longint unsigned acc;
        // exponent zero bypasses every reduction, even modulus one or zero
        if (e == 0)
            return 1;
        if (m == 0)
            return 0;
        md     = m;
        square = b % md;
        acc    = 1 % md;
        for (int i = 0; i < WORD_WIDTH; i++)
        begin
            if (e[i])
                acc = (acc * square) % md;
            square = (square * square) % md;
        end
        return acc[WORD_WIDTH-1:0];
    endfunction

    // Drop start and hold until the block is idle with no result outstanding
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_powers.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    // Write both key registers on back-to-back edges; call only when idle
    task automatic program_keys(input logic [WORD_WIDTH-1:0] m,
                                input logic [WORD_WIDTH-1:0] e);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MODULUS;
        cfg_data  <= m;
        @(posedge clk);
        cfg_index <= CFG_EXPONENT;
        cfg_data  <= e;
        @(posedge clk);
        cfg_we       <= 1'b0;
        key_modulus  = m;
        key_exponent = e;
        key_settings++;
    endtask

    // Offer one base after a random gap and hold it until the block takes it.
    // With a zero gap start stays high from the previous transaction, so a new
    // base can sit waiting through any part of the block's work.
    task automatic send_base(input logic [WORD_WIDTH-1:0] b,
                             input logic [WORD_WIDTH-1:0] power);
        int         gap;
        int         pick;
        power_txn_t txn;
        pick = $urandom_range(0, 99);
        if (steady || pick < 50)
            gap = 0;
        else if (pick < 75)
            gap = $urandom_range(1, 3);
        else if (pick < 90)
            gap = $urandom_range(4, 60);
        else
            gap = $urandom_range(61, 2500);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        base_value <= b;
        // busy read here is its value at the edge, so this edge took the base
        do
            @(posedge clk);
        while (busy);
        txn = '{b, key_modulus, key_exponent, power};
        pending_powers.insert(pending_powers.size(), txn);
        bases_sent++;
    endtask

    // Result checker: done is a one-cycle strobe, sample it at each edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_powers.size() == 0)
            begin
                $display("%0t: unexpected power_result %h, no transaction pending",
                         $time, power_result);
                fail_count++;
            end
            else
            begin
                oldest_power = pending_powers.pop_front();
                powers_checked++;
                if (power_result !== oldest_power.power)
                begin
                    $display("%0t: power_result expected %h actual %h (base %h mod %h exp %h)",
                             $time, oldest_power.power, power_result, oldest_power.base,
                             oldest_power.modulus, oldest_power.exponent);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_powers.size());
            $display("modular_exponentiation: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [WORD_WIDTH-1:0] next_modulus;
        logic [WORD_WIDTH-1:0] next_exponent;
        logic [WORD_WIDTH-1:0] next_base;
        int                    phase_len;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; the first rows run on the reset keys
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            if (DIRECTED[i].write_keys)
            begin
                wait_idle();
                program_keys(DIRECTED[i].modulus, DIRECTED[i].exponent);
            end
            send_base(DIRECTED[i].base,
                      DIRECTED[i].known ? DIRECTED[i].power
                                        : predict_power(key_modulus, key_exponent,
                                                        DIRECTED[i].base));
        end

        // Random phases: new keys, then a run of bases under them
        while (bases_sent < DIRECTED_COUNT + RANDOM_BASES)
        begin
            phase_len = $urandom_range(6, 30);
            case ($urandom_range(0, 9))
                0:       next_modulus = 32'd1;
                1:       next_modulus = 32'd0;
                2:       next_modulus = 32'hFFFFFFFF;
                3:       next_modulus = $urandom_range(2, 255);
                4:       next_modulus = $urandom_range(2, 65535);
                5:       next_modulus = $urandom | 32'h80000000;
                default: next_modulus = $urandom;
            endcase
            case ($urandom_range(0, 9))
                0:       next_exponent = 32'd0;
                1:       next_exponent = 32'hFFFFFFFF;
                2:       next_exponent = 32'd1;
                3:       next_exponent = $urandom_range(2, 65537);
                4:       next_exponent = 32'd1 << $urandom_range(0, 31);
                5:       next_exponent = ~(32'd1 << $urandom_range(0, 31));
                default: next_exponent = $urandom;
            endcase
            wait_idle();
            program_keys(next_modulus, next_exponent);
            // some phases offer each base with no gap, so start stays high throughout
            steady = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                case ($urandom_range(0, 9))
                    0:       next_base = 32'd0;
                    1:       next_base = 32'd1;
                    2:       next_base = 32'hFFFFFFFF;
                    3:       next_base = key_modulus - 1;
                    4:       next_base = key_modulus;
                    5:       next_base = key_modulus * $urandom_range(2, 3);
                    6:       next_base = $urandom_range(0, 255);
                    default: next_base = $urandom;
                endcase
                send_base(next_base, predict_power(key_modulus, key_exponent, next_base));
            end
        end

        // Drain, then stay a while to catch any stray strobe
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d bases under %0d key settings; %0d results checked, %0d failures.",
                 bases_sent, key_settings, powers_checked, fail_count);
        if (fail_count == 0)
            $display("modular_exponentiation: match");
        else
            $display("modular_exponentiation: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/modexp_pkg.sv
hdl/modexp_mulmod.sv
hdl/modular_exponentiation.sv
hdl/modexp_checker.sv
bench/modular_exponentiation_test.sv
